// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the command parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pcl_pkg.sv =====
package pcl_pkg;

    // Line buffer limit
    localparam int LINE_MAX_DEF = 32;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 32;
    localparam int COLOR_W = 32;
    localparam int KIND_W  = 3;
    localparam int CLEN_W  = 6;

    // Colour field length: saturation point and the two lengths that make a write
    localparam logic [CLEN_W-1:0] CLEN_MAX    = 6'd63;
    localparam logic [CLEN_W-1:0] CLEN_OPAQUE = 6'd6;
    localparam logic [CLEN_W-1:0] CLEN_ALPHA  = 6'd8;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_OPAQUE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALPHA  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SIZE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HELP   = 3'd4;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF_HEX = 8'h66;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;

    // Lengths of the command keywords
    localparam int PX_LEN   = 3;
    localparam int SIZE_LEN = 4;
    localparam int HELP_LEN = 4;

    // One decoded command
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
    } pcl_result_t;

    // Keyword characters by position
    function automatic logic [BYTE_W-1:0] px_char(input logic [1:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            2'd0:    c = CH_P;
            2'd1:    c = 8'h58;     // X
            2'd2:    c = CH_SPACE;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] size_char(input logic [1:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            2'd0:    c = CH_S;
            2'd1:    c = 8'h49;     // I
            2'd2:    c = 8'h5A;     // Z
            default: c = 8'h45;     // E
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] help_char(input logic [1:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            2'd0:    c = CH_H;
            2'd1:    c = 8'h45;     // E
            2'd2:    c = 8'h4C;     // L
            default: c = CH_P;
        endcase
        return c;
    endfunction

    // Hex digit test and value
    function automatic logic is_hex(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LA && b <= CH_LF_HEX) ||
               (b >= CH_UA && b <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            v = b - CH_ZERO;
        end else if (b >= CH_LA && b <= CH_LF_HEX) begin
            v = b - CH_LA + 8'd10;
        end else begin
            v = b - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/core/pixel_command_line_parser.sv =====
// Pixel command line parser: one byte per cycle in, one command per decoded line out.
// A command is registered into the output buffer when its newline byte is accepted.
// Throughput: one byte per cycle; the parser state updates once per accepted byte,
// and a two-slot output buffer stalls input only when two commands wait unread.
// Reset: synchronous active-low aresetn clears parser state and empties the output buffer.
module pixel_command_line_parser #(
    parameter int LINE_MAX = pcl_pkg::LINE_MAX_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] color_word
    output logic [2:0]   m_tuser    // [2:0] cmd_kind
);
    import pcl_pkg::*;

    logic        in_fire;
    logic        res_valid;
    pcl_result_t res;
    pcl_result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    pcl_decoder #(
        .LINE_MAX (LINE_MAX)
    ) u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    pcl_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // Pack the command onto the result channel
    assign m_tdata = {out_res.color, out_res.y, out_res.x};
    assign m_tuser = out_res.kind;

endmodule

// ===== rtl/core/pcl_decoder.sv =====
module pcl_decoder #(
    parameter int LINE_MAX = pcl_pkg::LINE_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_fire,
    input  logic [pcl_pkg::BYTE_W-1:0]  in_byte,
    output logic                        res_valid,
    output pcl_pkg::pcl_result_t        res
);
    import pcl_pkg::*;

    localparam int LEN_W = $clog2(LINE_MAX + 1);
    localparam logic [LEN_W-1:0] LINE_MAX_L = LEN_W'(LINE_MAX);
    localparam logic [LEN_W-1:0] PX_LAST    = LEN_W'(PX_LEN - 1);
    localparam logic [LEN_W-1:0] SIZE_LAST  = LEN_W'(SIZE_LEN - 1);
    localparam logic [LEN_W-1:0] HELP_LAST  = LEN_W'(HELP_LEN - 1);

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_PX      = 4'd1,
        PH_SIZE    = 4'd2,
        PH_HELP    = 4'd3,
        PH_SIZE_OK = 4'd4,
        PH_HELP_OK = 4'd5,
        PH_X       = 4'd6,
        PH_Y_EMPTY = 4'd7,
        PH_Y       = 4'd8,
        PH_COLOR   = 4'd9,
        PH_DEAD    = 4'd10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   line_length_reg, line_length_next;
    logic               skip_reg, skip_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [CLEN_W-1:0]  clen_reg, clen_next;
    logic               hex_stop_reg, hex_stop_next;

    logic [COORD_W-1:0] byte_ext;
    logic [COORD_W-1:0] x_dec;
    logic [COORD_W-1:0] y_dec;

    // Decimal digit step: acc * 10 + byte - '0', wrapping
    assign byte_ext = COORD_W'(in_byte);
    assign x_dec = (x_reg << 3) + (x_reg << 1) + byte_ext - COORD_W'(CH_ZERO);
    assign y_dec = (y_reg << 3) + (y_reg << 1) + byte_ext - COORD_W'(CH_ZERO);

    // Next state and result for one accepted byte
    always_comb begin
        phase_next       = phase_reg;
        line_length_next = line_length_reg;
        skip_next        = skip_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        color_next       = color_reg;
        clen_next        = clen_reg;
        hex_stop_next    = hex_stop_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (in_fire) begin
            if (skip_reg) begin
                // Drop an overlong line through its newline
                if (in_byte == CH_LF) begin
                    skip_next = 1'b0;
                end
            end else if (line_length_reg >= LINE_MAX_L) begin
                // Discard the full line
                phase_next       = PH_START;
                line_length_next = '0;
                x_next           = '0;
                y_next           = '0;
                color_next       = '0;
                clen_next        = '0;
                hex_stop_next    = 1'b0;
                skip_next        = (in_byte != CH_LF);
            end else if (in_byte == CH_CR) begin
                // Ignore carriage returns
            end else if (in_byte != CH_LF) begin
                line_length_next = line_length_reg + 1'b1;
                unique case (phase_reg)
                    PH_START: begin
                        if (in_byte == CH_P) begin
                            phase_next = PH_PX;
                        end else if (in_byte == CH_S) begin
                            phase_next = PH_SIZE;
                        end else if (in_byte == CH_H) begin
                            phase_next = PH_HELP;
                        end else begin
                            phase_next = PH_DEAD;
                        end
                    end
                    PH_PX: begin
                        if (line_length_reg > PX_LAST ||
                            in_byte != px_char(line_length_reg[1:0])) begin
                            phase_next = PH_DEAD;
                        end else if (line_length_reg == PX_LAST) begin
                            phase_next = PH_X;
                        end
                    end
                    PH_SIZE: begin
                        if (line_length_reg > SIZE_LAST ||
                            in_byte != size_char(line_length_reg[1:0])) begin
                            phase_next = PH_DEAD;
                        end else if (line_length_reg == SIZE_LAST) begin
                            phase_next = PH_SIZE_OK;
                        end
                    end
                    PH_HELP: begin
                        if (line_length_reg > HELP_LAST ||
                            in_byte != help_char(line_length_reg[1:0])) begin
                            phase_next = PH_DEAD;
                        end else if (line_length_reg == HELP_LAST) begin
                            phase_next = PH_HELP_OK;
                        end
                    end
                    PH_X: begin
                        if (in_byte == CH_SPACE) begin
                            phase_next = PH_Y_EMPTY;
                        end else if (in_byte == CH_NUL) begin
                            phase_next = PH_DEAD;
                        end else begin
                            x_next = x_dec;
                        end
                    end
                    PH_Y_EMPTY, PH_Y: begin
                        if (in_byte == CH_SPACE) begin
                            phase_next = PH_COLOR;
                        end else if (in_byte == CH_NUL) begin
                            phase_next = (phase_reg == PH_Y) ? PH_COLOR : PH_DEAD;
                        end else begin
                            y_next     = y_dec;
                            phase_next = PH_Y;
                        end
                    end
                    PH_COLOR: begin
                        if (clen_reg < CLEN_MAX) begin
                            clen_next = clen_reg + 1'b1;
                        end
                        if (!hex_stop_reg && is_hex(in_byte)) begin
                            color_next = {color_reg[COLOR_W-5:0], hex_nibble(in_byte)};
                        end else begin
                            hex_stop_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                // Newline: issue the decoded command, if the line was valid, and start a fresh line
                unique case (phase_reg)
                    PH_SIZE_OK: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_SIZE;
                    end
                    PH_HELP_OK: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_HELP;
                    end
                    PH_Y: begin
                        res_valid = 1'b1;
                        res.kind  = KIND_READ;
                        res.x     = x_reg;
                        res.y     = y_reg;
                    end
                    PH_COLOR: begin
                        if (clen_reg == CLEN_OPAQUE || clen_reg == CLEN_ALPHA) begin
                            res_valid = 1'b1;
                            res.kind  = (clen_reg == CLEN_OPAQUE) ? KIND_OPAQUE : KIND_ALPHA;
                            res.x     = x_reg;
                            res.y     = y_reg;
                            res.color = color_reg;
                        end
                    end
                    default: begin
                    end
                endcase
                phase_next       = PH_START;
                line_length_next = '0;
                x_next           = '0;
                y_next           = '0;
                color_next       = '0;
                clen_next        = '0;
                hex_stop_next    = 1'b0;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_START;
            line_length_reg <= '0;
            skip_reg        <= 1'b0;
            x_reg           <= '0;
            y_reg           <= '0;
            color_reg       <= '0;
            clen_reg        <= '0;
            hex_stop_reg    <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            line_length_reg <= line_length_next;
            skip_reg        <= skip_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
            color_reg       <= color_next;
            clen_reg        <= clen_next;
            hex_stop_reg    <= hex_stop_next;
        end
    end

`include "assert_macros.svh"

    `PCL_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, line_length_reg <= LINE_MAX_L, "line length past limit")
    `PCL_ASSERT_IMP(a_skip_clean, aclk, aresetn, skip_reg, phase_reg == PH_START && line_length_reg == '0, "skip with live line")
    `PCL_ASSERT_IMP(a_res_on_lf, aclk, aresetn, res_valid, in_fire && in_byte == CH_LF, "command without newline")

endmodule

// ===== rtl/core/pcl_out_buf.sv =====
module pcl_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  pcl_pkg::pcl_result_t in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output pcl_pkg::pcl_result_t out_data,
    input  logic                 out_ready
);
    import pcl_pkg::*;

    logic        out_valid_reg, out_valid_next;
    pcl_result_t out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    pcl_result_t skid_data_reg, skid_data_next;

    // Stall the byte stream only once the skid slot is taken
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Advance output register, park a request in the skid slot when stalled
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`include "assert_macros.svh"

    `PCL_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid full while output empty")
    `PCL_ASSERT_IMP(a_no_overrun, aclk, aresetn, in_valid, !skid_valid_reg, "request while both slots full")
    `PCL_ASSERT_NXT(a_park, aclk, aresetn, out_valid_reg && !out_ready && in_valid, skid_valid_reg, "stalled request lost")

endmodule
